/* hdl/dma_queue_hang_watchdog_defines.svh */
// Assertion macros for the DMA queue hang watchdog checker.
// Expects aclk and aresetn in scope at the point of use.
`ifndef DMA_QUEUE_HANG_WATCHDOG_DEFINES_SVH
`define DMA_QUEUE_HANG_WATCHDOG_DEFINES_SVH

// same-cycle implication, masked during reset
`define DQHW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, masked during reset
`define DQHW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, live through reset
`define DQHW_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* hdl/dqhw_pkg.sv */
// Types and constants shared by the DMA queue hang watchdog.
// No dependencies.
package dqhw_pkg;

    localparam int NUM_QUEUES = 5;
    localparam int POS_WIDTH  = 32;
    localparam int CFG_WIDTH  = 8;

    localparam logic [7:0] SAT_MAX = 8'hFF;

    localparam logic [7:0] DEF_BUMP_THRESHOLD  = 8'd4;
    localparam logic [7:0] DEF_STUCK_THRESHOLD = 8'd7;
    localparam logic [7:0] DEF_RESET_LIMIT     = 8'd2;
    localparam logic       DEF_BUMP_ENABLE     = 1'b0;

    typedef enum logic [1:0] {
        REG_BUMP_THRESHOLD  = 2'd0,
        REG_STUCK_THRESHOLD = 2'd1,
        REG_RESET_LIMIT     = 2'd2,
        REG_BUMP_ENABLE     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] bump_threshold;
        logic [7:0] stuck_threshold;
        logic [7:0] reset_limit;
        logic       bump_enable;
    } cfg_t;

    typedef struct packed {
        logic [NUM_QUEUES-1:0] empty_mask;
        logic [POS_WIDTH-1:0]  queue0_position;
        logic [POS_WIDTH-1:0]  queue1_position;
        logic [POS_WIDTH-1:0]  queue2_position;
        logic [POS_WIDTH-1:0]  queue3_position;
        logic [POS_WIDTH-1:0]  queue4_position;
        logic [31:0]           rx_total_delta;
        logic [31:0]           rx_overrun_delta;
    } in_word_t;

    typedef struct packed {
        logic                  mac_reset_now;
        logic [NUM_QUEUES-1:0] bump_mask;
        logic [NUM_QUEUES-1:0] stuck_mask;
        logic                  rx_kick;
        logic [7:0]            reset_pressure;
        logic [31:0]           rx_total_count;
        logic [31:0]           rx_overrun_count;
    } out_word_t;

endpackage

/* hdl/dqhw_queue.sv */
// Per-queue stall tracker: last seen position and saturating stall count.
// Depends on dqhw_pkg.
module dqhw_queue #(
    parameter int POS_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                empty,
    input  logic [POS_BITS-1:0] position,
    input  dqhw_pkg::cfg_t      cfg,
    input  logic                fire,
    output logic                stuck,
    output logic                bump
);
    import dqhw_pkg::*;

    logic [POS_BITS-1:0] last_pos_reg, last_pos_next;
    logic [7:0]          stall_reg, stall_next;
    logic [7:0]          stall_inc;
    logic                same;
    logic                stalled;

    assign same      = (position == last_pos_reg);
    assign stall_inc = (stall_reg == SAT_MAX) ? SAT_MAX : stall_reg + 8'd1;
    assign stalled   = !empty && same;
    assign stuck     = stalled && (stall_inc >= cfg.stuck_threshold);
    assign bump      = stalled && cfg.bump_enable && (stall_inc >= cfg.bump_threshold);

    always_comb begin
        last_pos_next = last_pos_reg;
        stall_next    = stall_reg;
        if (!empty) begin
            if (same) begin
                stall_next = stall_inc;
                if (stuck && fire) begin
                    stall_next    = '0;
                    last_pos_next = '0;
                end
            end else begin
                last_pos_next = position;
                stall_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
            stall_reg    <= '0;
        end else if (step) begin
            last_pos_reg <= last_pos_next;
            stall_reg    <= stall_next;
        end
    end

endmodule

/* hdl/dma_queue_hang_watchdog.sv */
// Top level of the DMA queue hang watchdog: input/output registers, config,
// reset pressure and RX tallies. Depends on dqhw_pkg and dqhw_queue.
//
// One input word is one watchdog tick. The block takes a tick every cycle while
// the output is not stalled: the tick lands in an input register, all five queue
// trackers plus the pressure logic evaluate it combinationally and update their
// state, and the result moves into an output register and sits there until
// taken. A stalled output backs up into the input register, then s_ready
// drops. Only the low ADDR_BITS bits of each queue position are compared
// (at most the 32 that the port carries). Config writes belong in idle time.
module dma_queue_hang_watchdog #(
    parameter int ADDR_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dqhw_pkg::in_word_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dqhw_pkg::out_word_t   m_data,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_wdata
);
    import dqhw_pkg::*;

    localparam int CMP_BITS = (ADDR_BITS < POS_WIDTH) ? ADDR_BITS : POS_WIDTH;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;
    out_word_t out_data_next;

    logic [7:0]  pressure_reg, pressure_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] overrun_reg, overrun_next;

    logic                  step;
    logic [CMP_BITS-1:0]   pos [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] stuck_vec;
    logic [NUM_QUEUES-1:0] bump_vec;
    logic [3:0]            stuck_cnt;
    logic                  all_overrun;
    logic                  kick;
    logic [9:0]            press_sum;
    logic [7:0]            press_inc;
    logic                  fire;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bump_threshold  <= DEF_BUMP_THRESHOLD;
            cfg_reg.stuck_threshold <= DEF_STUCK_THRESHOLD;
            cfg_reg.reset_limit     <= DEF_RESET_LIMIT;
            cfg_reg.bump_enable     <= DEF_BUMP_ENABLE;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_BUMP_THRESHOLD:  cfg_reg.bump_threshold  <= cfg_wdata;
                REG_STUCK_THRESHOLD: cfg_reg.stuck_threshold <= cfg_wdata;
                REG_RESET_LIMIT:     cfg_reg.reset_limit     <= cfg_wdata;
                REG_BUMP_ENABLE:     cfg_reg.bump_enable     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    // queue trackers
    assign pos[0] = in_data_reg.queue0_position[CMP_BITS-1:0];
    assign pos[1] = in_data_reg.queue1_position[CMP_BITS-1:0];
    assign pos[2] = in_data_reg.queue2_position[CMP_BITS-1:0];
    assign pos[3] = in_data_reg.queue3_position[CMP_BITS-1:0];
    assign pos[4] = in_data_reg.queue4_position[CMP_BITS-1:0];

    for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_queue
        dqhw_queue #(
            .POS_BITS (CMP_BITS)
        ) u_queue (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step     (step),
            .empty    (in_data_reg.empty_mask[i]),
            .position (pos[i]),
            .cfg      (cfg_reg),
            .fire     (fire),
            .stuck    (stuck_vec[i]),
            .bump     (bump_vec[i])
        );
    end

    // pressure and RX tallies
    assign stuck_cnt   = 4'($countones(stuck_vec));
    assign kick        = (in_data_reg.rx_overrun_delta != '0);
    assign all_overrun = kick && (in_data_reg.rx_overrun_delta == in_data_reg.rx_total_delta);
    assign press_sum   = {2'b00, pressure_reg} + {6'd0, stuck_cnt} + {9'd0, all_overrun};
    assign press_inc   = (press_sum > {2'b00, SAT_MAX}) ? SAT_MAX : press_sum[7:0];
    assign fire        = (press_inc >= cfg_reg.reset_limit);

    always_comb begin
        if (fire) begin
            pressure_next = '0;
        end else if (press_inc != '0 && press_inc == pressure_reg) begin
            pressure_next = press_inc - 8'd1;
        end else begin
            pressure_next = press_inc;
        end
    end

    assign total_next   = total_reg + in_data_reg.rx_total_delta;
    assign overrun_next = overrun_reg + in_data_reg.rx_overrun_delta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_reg <= '0;
            total_reg    <= '0;
            overrun_reg  <= '0;
        end else if (step) begin
            pressure_reg <= pressure_next;
            total_reg    <= total_next;
            overrun_reg  <= overrun_next;
        end
    end

    always_comb begin
        out_data_next.mac_reset_now    = fire;
        out_data_next.bump_mask        = bump_vec;
        out_data_next.stuck_mask       = stuck_vec;
        out_data_next.rx_kick          = kick;
        out_data_next.reset_pressure   = pressure_next;
        out_data_next.rx_total_count   = total_next;
        out_data_next.rx_overrun_count = overrun_next;
    end

endmodule

/* hdl/dqhw_checker.sv */
// Port-level checks for the DMA queue hang watchdog, bound to the top level.
// Depends on dqhw_pkg and dma_queue_hang_watchdog_defines.svh.
`include "dma_queue_hang_watchdog_defines.svh"

module dqhw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dqhw_pkg::out_word_t m_data
);
    import dqhw_pkg::*;

    `DQHW_ASSERT_RST(a_reset_empties, !aresetn, !m_valid)
    `DQHW_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `DQHW_ASSERT_NOW(a_fire_clears, m_valid && m_data.mac_reset_now, m_data.reset_pressure == 8'd0)
    `DQHW_ASSERT_NOW(a_accept_result, s_valid && !s_ready, m_valid && !m_ready)

endmodule

bind dma_queue_hang_watchdog dqhw_checker u_dqhw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
